// File: src/gpbc_pkg.sv
`default_nettype none

package gpbc_pkg;

   // Blend mode codes held in the configuration register
   typedef enum logic [2:0] {
      MODE_NORMAL     = 3'd0,
      MODE_MULTIPLY   = 3'd1,
      MODE_SCREEN     = 3'd2,
      MODE_DARKEN     = 3'd3,
      MODE_LIGHTEN    = 3'd4,
      MODE_DIFFERENCE = 3'd5
   } blend_mode_type;

   localparam int PIXEL_W = 8;
   localparam int MODE_W  = 3;

   // Full-scale pixel value and the composite normalizer (255 squared)
   localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;
   localparam logic [23:0]        NORM      = 24'd65025;
   localparam logic [17:0]        NORM_X1   = 18'd65025;
   localparam logic [17:0]        NORM_X2   = 18'd130050;

   // Rounding bias that turns a floor division by 255 into a ceiling
   localparam logic [16:0] CEIL_BIAS = 17'd254;

endpackage

`default_nettype wire

// File: src/gpbc_channels.sv
`default_nettype none

// Pixel request channel
interface gpbc_req_if;
   logic                        valid;
   logic                        ready;
   logic [gpbc_pkg::PIXEL_W-1:0] source_pixel;
   logic [gpbc_pkg::PIXEL_W-1:0] backdrop_pixel;
   logic [gpbc_pkg::PIXEL_W-1:0] alpha_value;
   logic                        last_pixel;

   modport source (output valid, source_pixel, backdrop_pixel, alpha_value, last_pixel,
                   input ready);
   modport sink   (input valid, source_pixel, backdrop_pixel, alpha_value, last_pixel,
                   output ready);
endinterface

// Composited pixel response channel
interface gpbc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gpbc_pkg::PIXEL_W-1:0] result_pixel;
   logic                        end_of_image;

   modport source (output valid, result_pixel, end_of_image, input ready);
   modport sink   (input valid, result_pixel, end_of_image, output ready);
endinterface

// Blend mode register write channel
interface gpbc_csr_if;
   logic                       valid;
   logic                       ready;
   logic [gpbc_pkg::MODE_W-1:0] blend_mode;

   modport source (output valid, blend_mode, input ready);
   modport sink   (input valid, blend_mode, output ready);
endinterface

`default_nettype wire

// File: src/gray_pixel_blend_composite_unit.sv
// Gray pixel blend and composite unit.
//
// Each request on req_bus carries one grayscale source pixel, backdrop pixel
// and alpha, plus a last-pixel mark. The unit blends source and backdrop by
// the mode in its one register, then composites the blend with both layers
// weighted by alpha and 255 - alpha, and returns one response on rsp_bus
// with the 8-bit result and the end-of-image mark copied from the request.
//
// Throughput is one request per clock while rsp_bus keeps taking responses.
// The six register stages are products of the inputs, the blend value, the
// weighted products, their sum, a quotient estimate with its remainder, and
// the corrected quotient.
// Every stage holds its own valid bit, so an empty stage keeps accepting
// while the response waits: a stalled receiver fills the bubbles first and
// then backs req_bus.ready off, with nothing lost or repeated.
//
// csr_bus writes the blend mode; it is always ready and should be written
// only while no request is in flight. Synchronous reset empties every stage
// and sets the mode to normal.
`default_nettype none

module gray_pixel_blend_composite_unit (
   input  wire logic      clock,
   input  wire logic      reset,
   gpbc_req_if.sink       req_bus,
   gpbc_rsp_if.source     rsp_bus,
   gpbc_csr_if.sink       csr_bus
);

   // Floor division by 255, exact for values below 65280
   function automatic logic [7:0] div255(input logic [16:0] x);
      logic [16:0] t;
      t = x + 17'd1 + {8'd0, x[16:8]};
      return t[15:8];
   endfunction

   // Configuration register
   gpbc_pkg::blend_mode_type mode_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= gpbc_pkg::MODE_NORMAL;
      end else if (csr_bus.valid) begin
         mode_ff <= gpbc_pkg::blend_mode_type'(csr_bus.blend_mode);
      end
   end

   // Stage valid bits and per-stage advance
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6 = !v6_ff || rsp_bus.ready;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_bus.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // Stage 1: pixel product and the three alpha weights
   logic [15:0] prod_ff, aa1_ff, bb1_ff, ab1_ff;
   logic [7:0]  cs1_ff, cb1_ff;
   logic        last1_ff;
   logic [7:0]  beta_in;

   assign beta_in = gpbc_pkg::PIXEL_MAX - req_bus.alpha_value;

   always_ff @(posedge clock) begin
      if (en1) begin
         prod_ff  <= 16'(req_bus.backdrop_pixel) * 16'(req_bus.source_pixel);
         aa1_ff   <= 16'(req_bus.alpha_value) * 16'(req_bus.alpha_value);
         bb1_ff   <= 16'(beta_in) * 16'(beta_in);
         ab1_ff   <= 16'(req_bus.alpha_value) * 16'(beta_in);
         cs1_ff   <= req_bus.source_pixel;
         cb1_ff   <= req_bus.backdrop_pixel;
         last1_ff <= req_bus.last_pixel;
      end
   end

   // Stage 2: blend value by mode
   logic [7:0]  blend_in, blend2_ff, cs2_ff, cb2_ff;
   logic [15:0] aa2_ff, bb2_ff, ab2_ff;
   logic        last2_ff;
   logic [7:0]  mul_q, ceil_q;
   logic [8:0]  screen_sum;

   always_comb begin
      mul_q      = div255({1'b0, prod_ff});
      ceil_q     = div255({1'b0, prod_ff} + gpbc_pkg::CEIL_BIAS);
      screen_sum = 9'(cb1_ff) + 9'(cs1_ff) - 9'(ceil_q);
      case (mode_ff)
         gpbc_pkg::MODE_NORMAL:     blend_in = cs1_ff;
         gpbc_pkg::MODE_MULTIPLY:   blend_in = mul_q;
         gpbc_pkg::MODE_SCREEN:     blend_in = screen_sum[7:0];
         gpbc_pkg::MODE_DARKEN:     blend_in = (cb1_ff < cs1_ff) ? cb1_ff : cs1_ff;
         gpbc_pkg::MODE_LIGHTEN:    blend_in = (cb1_ff > cs1_ff) ? cb1_ff : cs1_ff;
         gpbc_pkg::MODE_DIFFERENCE: blend_in = (cb1_ff > cs1_ff) ? cb1_ff - cs1_ff
                                                                 : cs1_ff - cb1_ff;
         default:                   blend_in = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         blend2_ff <= blend_in;
         aa2_ff    <= aa1_ff;
         bb2_ff    <= bb1_ff;
         ab2_ff    <= ab1_ff;
         cs2_ff    <= cs1_ff;
         cb2_ff    <= cb1_ff;
         last2_ff  <= last1_ff;
      end
   end

   // Stage 3: weighted products
   logic [23:0] pbb_ff, paa_ff, pab_ff;
   logic        last3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         pbb_ff   <= 24'(bb2_ff) * 24'(cb2_ff);
         paa_ff   <= 24'(aa2_ff) * 24'(cs2_ff);
         pab_ff   <= 24'(ab2_ff) * 24'(blend2_ff);
         last3_ff <= last2_ff;
      end
   end

   // Stage 4: accumulate; the sum never exceeds 255 * 65025
   logic [25:0] sum_in;
   logic [23:0] acc_ff;
   logic        last4_ff;

   assign sum_in = 26'(pbb_ff) + 26'(paa_ff) + 26'(pab_ff);

   always_ff @(posedge clock) begin
      if (en4) begin
         acc_ff   <= sum_in[23:0];
         last4_ff <= last3_ff;
      end
   end

   // Stage 5: quotient estimate by shift, at most two short of the true value
   logic [7:0]  q0_in, q5_ff;
   logic [23:0] rem_in;
   logic [17:0] rem5_ff;
   logic        last5_ff;

   assign q0_in  = acc_ff[23:16];
   assign rem_in = acc_ff - 24'(q0_in) * gpbc_pkg::NORM;

   always_ff @(posedge clock) begin
      if (en5) begin
         q5_ff    <= q0_in;
         rem5_ff  <= rem_in[17:0];
         last5_ff <= last4_ff;
      end
   end

   // Stage 6: correct the estimate from the remainder
   logic [7:0] q_in, result_ff;
   logic       last6_ff;

   assign q_in = q5_ff + 8'(rem5_ff >= gpbc_pkg::NORM_X1)
                       + 8'(rem5_ff >= gpbc_pkg::NORM_X2);

   always_ff @(posedge clock) begin
      if (en6) begin
         result_ff <= q_in;
         last6_ff  <= last5_ff;
      end
   end

   assign rsp_bus.valid        = v6_ff;
   assign rsp_bus.result_pixel = result_ff;
   assign rsp_bus.end_of_image = last6_ff;

endmodule

`default_nettype wire

// File: src/gpbc_checker.sv
`default_nettype none

module gpbc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_result_pixel,
   input wire logic       rsp_end_of_image
);

   // Track requests in flight
   logic [3:0] flight_ff;
   logic [3:0] flight_in;

   always_comb begin
      flight_in = flight_ff;
      if (req_valid && req_ready)  flight_in = flight_in + 4'd1;
      if (rsp_valid && rsp_ready)  flight_in = flight_in - 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= 4'd0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_pixel)
                                  && $stable(rsp_end_of_image))
      else $error("stalled response changed");

   // Drop all responses at reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Never invent a response
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> flight_ff != 4'd0)
      else $error("response without a request in flight");

   // Bound the pipeline occupancy by its six stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      flight_ff <= 4'd6)
      else $error("more requests in flight than stages");

endmodule

bind gray_pixel_blend_composite_unit gpbc_checker u_gpbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_result_pixel (rsp_bus.result_pixel),
   .rsp_end_of_image (rsp_bus.end_of_image)
);

`default_nettype wire
